// ===== src/mmrp_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the reply parser.
`timescale 1ns / 1ps
package mmrp_pkg;

	// Frame layout and protocol constants.
	localparam int unsigned FRAME_LEN = 17;
	localparam int unsigned POS_SAT = 18;
	localparam int unsigned DATA_LEN = 12;
	localparam int unsigned HDR_LEN = 3;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
	localparam logic [7:0] BYTE_COUNT = 8'd12;
	localparam logic [15:0] JOULES_PER_10WH = 16'd36000;
	localparam logic [7:0] DEV_ADDR_RESET = 8'd1;

	// Result status codes, checked in this order.
	typedef enum logic [2:0] {
		STATUS_OK,
		STATUS_CRC,
		STATUS_ADDR,
		STATUS_FUNC,
		STATUS_COUNT
	} status_t;

	// One classified frame, passed from the front to the back.
	typedef struct packed {
		status_t status;
		logic [DATA_LEN-1:0][7:0] data;
	} frame_t;

	// One finished result beat.
	typedef struct packed {
		status_t status;
		logic [15:0] voltage;
		logic [15:0] current;
		logic [31:0] power;
		logic [47:0] energy;
	} result_t;

	// CRC-16/MODBUS update over one byte, LSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== src/mmrp_queue.sv =====
// Small first-in first-out queue used between the stages of the parser.
`timescale 1ns / 1ps
module mmrp_queue #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [Width-1:0] rdata,
	output logic             empty
);
	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CntW'(Depth));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	// Storage is written at the tail; no reset needed on payload.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/mmrp_front.sv =====
// Front end: takes received bytes, runs the CRC, captures fields, classifies frames.
`timescale 1ns / 1ps
module mmrp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata,
	input  logic            accept,
	input  logic [7:0]      rx_byte,
	input  logic            frame_end,
	output logic            frame_push,
	output mmrp_pkg::frame_t frame_data
);
	import mmrp_pkg::*;

	logic [7:0] dev_addr_q;
	logic [15:0] crc_q;
	logic [4:0] pos_q;
	logic [7:0] addr_q;
	logic [7:0] func_q;
	logic [7:0] count_q;
	logic [DATA_LEN-1:0][7:0] data_q;

	logic [15:0] crc_next;
	logic [4:0] pos_next;
	logic [7:0] addr_cur;
	logic [7:0] func_cur;
	logic [7:0] count_cur;
	logic data_slot;
	logic [3:0] data_idx;
	status_t status;

	// Running CRC and saturating byte position.
	assign crc_next = crc_byte(crc_q, rx_byte);
	assign pos_next = (pos_q < 5'(POS_SAT)) ? pos_q + 5'd1 : pos_q;
	assign data_slot = (pos_q >= 5'(HDR_LEN)) && (pos_q < 5'(HDR_LEN + DATA_LEN));
	assign data_idx = 4'(pos_q - 5'(HDR_LEN));

	// Header fields as they stand after this byte is captured.
	assign addr_cur = (pos_q == 5'd0) ? rx_byte : addr_q;
	assign func_cur = (pos_q == 5'd1) ? rx_byte : func_q;
	assign count_cur = (pos_q == 5'd2) ? rx_byte : count_q;

	// Checks in order: length and CRC, address, function, byte count.
	always_comb begin
		if (pos_next != 5'(FRAME_LEN) || crc_next != 16'h0000) begin
			status = STATUS_CRC;
		end else if (addr_cur != dev_addr_q) begin
			status = STATUS_ADDR;
		end else if (func_cur != FUNC_READ_HOLDING) begin
			status = STATUS_FUNC;
		end else if (count_cur != BYTE_COUNT) begin
			status = STATUS_COUNT;
		end else begin
			status = STATUS_OK;
		end
	end

	assign frame_push = accept && frame_end;
	assign frame_data.status = status;
	assign frame_data.data = data_q;

	// Data bytes are written into their slots as they arrive; slots are not cleared between frames.
	always_ff @(posedge clk) begin
		if (accept && data_slot) begin
			data_q[data_idx] <= rx_byte;
		end
	end

	// Frame state; the end of a frame returns it to its start values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RESET;
			crc_q <= CRC_INIT;
			pos_q <= '0;
			addr_q <= '0;
			func_q <= '0;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				dev_addr_q <= cfg_wdata;
			end
			if (accept) begin
				if (frame_end) begin
					crc_q <= CRC_INIT;
					pos_q <= '0;
					addr_q <= '0;
					func_q <= '0;
					count_q <= '0;
				end else begin
					crc_q <= crc_next;
					pos_q <= pos_next;
					addr_q <= addr_cur;
					func_q <= func_cur;
					count_q <= count_cur;
				end
			end
		end
	end

endmodule

// ===== src/mmrp_back.sv =====
// Back end: turns a classified frame into meter values, including the energy scaling.
`timescale 1ns / 1ps
module mmrp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             frame_valid,
	input  mmrp_pkg::frame_t frame_data,
	output logic             frame_take,
	output logic             res_valid,
	output mmrp_pkg::result_t res_data,
	input  logic             res_ready
);
	import mmrp_pkg::*;

	logic valid_s1;
	result_t res_s1;
	logic move_s1;
	logic ok;
	logic [31:0] energy_raw;

	// The stage empties into the output queue whenever it has room.
	assign move_s1 = valid_s1 && res_ready;
	assign frame_take = frame_valid && (!valid_s1 || res_ready);
	assign res_valid = valid_s1;
	assign res_data = res_s1;

	assign ok = (frame_data.status == STATUS_OK);
	assign energy_raw = {frame_data.data[8], frame_data.data[9],
		frame_data.data[10], frame_data.data[11]};

	// Field extraction and the 32 by 16 multiply into joules.
	always_ff @(posedge clk) begin
		if (frame_take) begin
			res_s1.status <= frame_data.status;
			res_s1.voltage <= ok ? {frame_data.data[0], frame_data.data[1]} : '0;
			res_s1.current <= ok ? {frame_data.data[2], frame_data.data[3]} : '0;
			res_s1.power <= ok ? {frame_data.data[4], frame_data.data[5],
				frame_data.data[6], frame_data.data[7]} : '0;
			res_s1.energy <= ok ? (48'(energy_raw) * 48'(JOULES_PER_10WH)) : '0;
		end
	end

	// Stage occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_take) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

// ===== src/modbus_meter_response_parser_core.sv =====
// Top level of the reply parser: front end, frame queue, back end and result queue.
`timescale 1ns / 1ps
// Usage:
// Bytes of a reply frame enter on rx_byte with frame_end marking the last one;
// a beat is taken on a clock edge with push high and full low. One byte can be
// taken in every cycle while full is low. Each last byte makes exactly one result
// beat; other bytes make none. Results leave in order: while empty is low the oldest
// result is on status and the value ports, and a beat is taken when pop is high.
// Path: the result of a last byte passes through the frame queue, then the multiply
// stage, then the result queue, each of which holds it in registers.
// Throughput: one byte per cycle while full is low and one result per cycle while
// pop is high; the CRC byte update in the front end is combinational.
// When the receiver stalls, the result queue and then the frame queue fill;
// full rises once the frame queue has no room, and bytes wait.
// cfg_we writes cfg_wdata into the device address; write it only while idle.
// Reset (arst_n low) empties both queues, restarts frame capture and sets the
// device address to 1.
module modbus_meter_response_parser_core #(
	parameter int unsigned MidDepth = 2,
	parameter int unsigned OutDepth = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	input  logic        frame_end,
	input  logic        pop,
	output logic        empty,
	output logic [2:0]  status,
	output logic [15:0] voltage_decivolts,
	output logic [15:0] current_centiamps,
	output logic [31:0] power_decawatts_tenth,
	output logic [47:0] energy_joules
);
	import mmrp_pkg::*;

	logic accept;
	logic frame_push;
	frame_t frame_in;
	frame_t frame_out;
	logic frame_empty;
	logic frame_take;
	logic res_valid;
	result_t res_in;
	result_t res_out;
	logic res_full;

	assign accept = push && !full;

	// Front end: byte capture and classification.
	mmrp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.accept     (accept),
		.rx_byte    (rx_byte),
		.frame_end  (frame_end),
		.frame_push (frame_push),
		.frame_data (frame_in)
	);

	// Queue of classified frames between the two halves.
	mmrp_queue #(
		.Width ($bits(frame_t)),
		.Depth (MidDepth)
	) u_frame_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (frame_push),
		.wdata  (frame_in),
		.full   (full),
		.pop    (frame_take),
		.rdata  (frame_out),
		.empty  (frame_empty)
	);

	// Back end: value extraction and energy scaling.
	mmrp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (!frame_empty),
		.frame_data  (frame_out),
		.frame_take  (frame_take),
		.res_valid   (res_valid),
		.res_data    (res_in),
		.res_ready   (!res_full)
	);

	// Result queue facing the receiver.
	mmrp_queue #(
		.Width ($bits(result_t)),
		.Depth (OutDepth)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign status = res_out.status;
	assign voltage_decivolts = res_out.voltage;
	assign current_centiamps = res_out.current;
	assign power_decawatts_tenth = res_out.power;
	assign energy_joules = res_out.energy;

	// A shown result carries a defined status code.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status <= 3'(STATUS_COUNT)))
		else $error("result status out of range");

	// A failed frame reports no values.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != 3'(STATUS_OK)) |->
		(voltage_decivolts == '0 && current_centiamps == '0 &&
		power_decawatts_tenth == '0 && energy_joules == '0))
		else $error("failed frame reports nonzero values");

	// A byte that ends no frame never fills the frame queue by itself.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_empty && !(accept && frame_end)) |=> frame_empty)
		else $error("frame queued without a last byte");

endmodule

// ===== sim/modbus_meter_response_parser_core_tb.sv =====
// Self-checking testbench for the Modbus meter reply parser core.
`timescale 1ns / 1ps
module modbus_meter_response_parser_core_tb;
	import mmrp_pkg::*;

	localparam int unsigned PHASES = 6;
	localparam int unsigned BYTE_BUDGET = 1150;
	localparam int unsigned REPORT_LIMIT = 10;
	localparam int unsigned SETTLE_CYCLES = 4;

	// Kinds of reply frame that the stimulus can build.
	typedef enum int unsigned {
		KIND_GOOD,
		KIND_ZERO,
		KIND_FULL,
		KIND_BAD_ADDR,
		KIND_BAD_FUNC,
		KIND_BAD_COUNT,
		KIND_BAD_CRC,
		KIND_BAD_LEN,
		KIND_NOISE
	} frame_kind_t;

	// Tracks the parser state byte by byte and holds the readings it should report.
	class reply_checker_t;
		logic [7:0] dev_addr;
		logic [15:0] crc;
		int unsigned pos;
		logic [7:0] addr_b;
		logic [7:0] func_b;
		logic [7:0] count_b;
		logic [7:0] data_b [DATA_LEN];
		result_t pending_readings[$];
		int unsigned mismatches;
		int unsigned status_seen [5];

		function new();
			dev_addr = DEV_ADDR_RESET;
			mismatches = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
			clear_frame();
		endfunction

		// CRC-16/MODBUS over one byte, shifted out LSB first.
		static function logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
			logic [15:0] r;
			r = c ^ {8'h00, b};
			repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
			return r;
		endfunction

		function void clear_frame();
			crc = CRC_INIT;
			pos = 0;
			addr_b = '0;
			func_b = '0;
			count_b = '0;
			foreach (data_b[i]) data_b[i] = '0;
		endfunction

		// Notes one accepted byte; on the last byte of a frame it queues the reading.
		function void take_byte(input logic [7:0] b, input logic last);
			result_t r;
			status_t st;
			logic [31:0] e32;
			logic [63:0] prod;
			crc = crc_next(crc, b);
			if (pos == 0) begin
				addr_b = b;
			end else if (pos == 1) begin
				func_b = b;
			end else if (pos == 2) begin
				count_b = b;
			end else if (pos < HDR_LEN + DATA_LEN) begin
				data_b[pos - HDR_LEN] = b;
			end
			if (pos < POS_SAT) pos++;
			if (!last) return;

			if (pos != FRAME_LEN || crc != 16'h0000) st = STATUS_CRC;
			else if (addr_b != dev_addr) st = STATUS_ADDR;
			else if (func_b != FUNC_READ_HOLDING) st = STATUS_FUNC;
			else if (count_b != BYTE_COUNT) st = STATUS_COUNT;
			else st = STATUS_OK;

			r = '0;
			r.status = st;
			if (st == STATUS_OK) begin
				r.voltage = {data_b[0], data_b[1]};
				r.current = {data_b[2], data_b[3]};
				r.power = {data_b[4], data_b[5], data_b[6], data_b[7]};
				e32 = {data_b[8], data_b[9], data_b[10], data_b[11]};
				prod = 64'(e32) * 64'(JOULES_PER_10WH);
				r.energy = prod[47:0];
			end
			pending_readings.push_back(r);
			clear_frame();
		endfunction

		// Compares one result beat with the oldest queued reading.
		function void check_reading(input result_t got);
			result_t want;
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: result beat with nothing queued, status %0d",
						$realtime, got.status);
				return;
			end
			want = pending_readings.pop_front();
			status_seen[int'(want.status)]++;
			if (got.status !== want.status || got.voltage !== want.voltage ||
					got.current !== want.current || got.power !== want.power ||
					got.energy !== want.energy) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: reading mismatch", $realtime);
					$display("  expected status %0d V %h I %h P %h E %h", want.status,
						want.voltage, want.current, want.power, want.energy);
					$display("  actual   status %0d V %h I %h P %h E %h", got.status,
						got.voltage, got.current, got.power, got.energy);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;
	logic push = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic frame_end = 1'b0;
	logic pop = 1'b0;
	wire full;
	wire empty;
	wire [2:0] status;
	wire [15:0] voltage_decivolts;
	wire [15:0] current_centiamps;
	wire [31:0] power_decawatts_tenth;
	wire [47:0] energy_joules;

	reply_checker_t readings = new();
	logic calm = 1'b0;
	logic [7:0] frame_q[$];
	int unsigned bytes_sent = 0;
	int unsigned frames_sent = 0;
	int unsigned pop_hold = 0;

	always #5 clk = ~clk;

	modbus_meter_response_parser_core dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cfg_we                (cfg_we),
		.cfg_wdata             (cfg_wdata),
		.push                  (push),
		.full                  (full),
		.rx_byte               (rx_byte),
		.frame_end             (frame_end),
		.pop                   (pop),
		.empty                 (empty),
		.status                (status),
		.voltage_decivolts     (voltage_decivolts),
		.current_centiamps     (current_centiamps),
		.power_decawatts_tenth (power_decawatts_tenth),
		.energy_joules         (energy_joules)
	);

	// Builds one reply frame in frame_q; addr is the address a good reply carries.
	function automatic void build_frame(input frame_kind_t kind, input logic [7:0] addr);
		logic [15:0] c;
		int unsigned n;
		int unsigned k;
		frame_q.delete();
		if (kind == KIND_NOISE) begin
			n = $urandom_range(1, 30);
			repeat (n) frame_q.push_back(8'($urandom));
			return;
		end
		frame_q.push_back(kind == KIND_BAD_ADDR ? addr ^ 8'($urandom_range(1, 255)) : addr);
		if (kind == KIND_BAD_FUNC) begin
			do c[7:0] = 8'($urandom); while (c[7:0] == FUNC_READ_HOLDING);
			frame_q.push_back(c[7:0]);
		end else begin
			frame_q.push_back(FUNC_READ_HOLDING);
		end
		if (kind == KIND_BAD_COUNT) begin
			do c[7:0] = 8'($urandom); while (c[7:0] == BYTE_COUNT);
			frame_q.push_back(c[7:0]);
		end else begin
			frame_q.push_back(BYTE_COUNT);
		end
		// Data bytes lean toward the extremes now and then.
		for (int i = 0; i < DATA_LEN; i++) begin
			if (kind == KIND_ZERO) frame_q.push_back(8'h00);
			else if (kind == KIND_FULL) frame_q.push_back(8'hFF);
			else if ($urandom_range(0, 7) == 0) frame_q.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
			else frame_q.push_back(8'($urandom));
		end
		// A wrong-length frame keeps a valid CRC over whatever body it has.
		if (kind == KIND_BAD_LEN) begin
			n = $urandom_range(0, 1) ? $urandom_range(1, 14) : $urandom_range(16, 28);
			while (frame_q.size() > n) void'(frame_q.pop_back());
			while (frame_q.size() < n) frame_q.push_back(8'($urandom));
		end
		c = CRC_INIT;
		foreach (frame_q[i]) c = reply_checker_t::crc_next(c, frame_q[i]);
		frame_q.push_back(c[7:0]);
		frame_q.push_back(c[15:8]);
		// A single flipped bit is always caught by the CRC.
		if (kind == KIND_BAD_CRC) begin
			k = $urandom_range(0, frame_q.size() - 1);
			frame_q[k] = frame_q[k] ^ (8'h01 << $urandom_range(0, 7));
		end
	endfunction

	function automatic frame_kind_t pick_kind();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return KIND_GOOD;
		if (r < 54) return KIND_ZERO;
		if (r < 58) return KIND_FULL;
		if (r < 66) return KIND_BAD_ADDR;
		if (r < 74) return KIND_BAD_FUNC;
		if (r < 82) return KIND_BAD_COUNT;
		if (r < 90) return KIND_BAD_CRC;
		if (r < 95) return KIND_BAD_LEN;
		return KIND_NOISE;
	endfunction

	// Sends one byte beat, sometimes after a burst of idle cycles.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned n;
		if (!calm && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 17);
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		frame_end <= last;
		do @(posedge clk); while (full);
		readings.take_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
		frames_sent++;
	endtask

	// Holds off the sender until every queued reading has come back.
	task automatic wait_drained();
		push <= 1'b0;
		while (readings.pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_address(input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		readings.dev_addr = v;
		cfg_we <= 1'b0;
	endtask

	// Result side: check each popped beat, and stall pop in random bursts.
	always @(posedge clk) begin : result_side
		result_t got;
		if (pop && !empty) begin
			got.status = status_t'(status);
			got.voltage = voltage_decivolts;
			got.current = current_centiamps;
			got.power = power_decawatts_tenth;
			got.energy = energy_joules;
			readings.check_reading(got);
		end
		if (pop_hold != 0) begin
			pop_hold--;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			pop_hold = $urandom_range(1, 17) - 1;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// Main sequence: reset, a few directed frames, then random phases per address.
	initial begin : stimulus
		logic [7:0] addr_plan [PHASES];
		int unsigned target;
		addr_plan[0] = DEV_ADDR_RESET;
		addr_plan[1] = 8'h00;
		addr_plan[2] = 8'hFF;
		addr_plan[3] = 8'($urandom);
		addr_plan[4] = 8'hA5;
		addr_plan[5] = 8'($urandom);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: largest values at the reset address, then very short frames.
		build_frame(KIND_FULL, DEV_ADDR_RESET);
		send_frame();
		frame_q.delete();
		frame_q.push_back(8'h00);
		send_frame();
		frame_q.delete();
		frame_q.push_back(8'hFF);
		frame_q.push_back(8'h00);
		send_frame();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				wait_drained();
				write_address(addr_plan[ph]);
			end
			if (ph == PHASES - 1) calm = 1'b1;
			target = (ph + 1) * BYTE_BUDGET / PHASES;
			while (bytes_sent < target) begin
				build_frame(pick_kind(), readings.dev_addr);
				send_frame();
			end
		end

		push <= 1'b0;
		while (readings.pending_readings.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d bytes in %0d frames across %0d device addresses.",
			bytes_sent, frames_sent, PHASES);
		$display("Readings by status: ok %0d, crc/length %0d, address %0d, function %0d, count %0d.",
			readings.status_seen[0], readings.status_seen[1], readings.status_seen[2],
			readings.status_seen[3], readings.status_seen[4]);
		if (readings.mismatches == 0 && readings.pending_readings.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatching beats", readings.mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin : watchdog
		#5000000;
		$display("Timed out with %0d readings outstanding.", readings.pending_readings.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
src/mmrp_pkg.sv
src/mmrp_queue.sv
src/mmrp_front.sv
src/mmrp_back.sv
src/modbus_meter_response_parser_core.sv
sim/modbus_meter_response_parser_core_tb.sv
